// ===== hdl/lrucm_pkg.sv =====
// Shared constants, status codes and control types for the LRU cache
// with miss merging. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lrucm_pkg;
  localparam int CacheDepth = 16;
  localparam int PendDepth  = 8;
  localparam int KeyW       = 32;
  localparam int HandleW    = 32;
  localparam int WaitW      = 8;
  localparam int CfgW       = 5;
  localparam int StatusW    = 3;
  localparam int RankW      = $clog2(CacheDepth);
  localparam int CntW       = $clog2(CacheDepth + 1);

  localparam logic [CfgW-1:0] CfgReset = CfgW'(CacheDepth);

  // Result status codes.
  localparam logic [StatusW-1:0] StHit      = 3'd0;
  localparam logic [StatusW-1:0] StMerged   = 3'd1;
  localparam logic [StatusW-1:0] StIssue    = 3'd2;
  localparam logic [StatusW-1:0] StInserted = 3'd3;
  localparam logic [StatusW-1:0] StFailed   = 3'd4;
  localparam logic [StatusW-1:0] StNull     = 3'd5;
  localparam logic [StatusW-1:0] StPendFull = 3'd6;
  localparam logic [StatusW-1:0] StNotPend  = 3'd7;

  // Command codes of an input word.
  localparam logic CmdRequest  = 1'b0;
  localparam logic CmdComplete = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture the input word
    logic lookup;  // register the tag compares
    logic exec;    // update the stores and write the result word
  } lrucm_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic key_null;  // captured word carries the null key
  } lrucm_stat_t;
endpackage
`default_nettype wire

// ===== hdl/lrucm_req_if.sv =====
// Request channel: command, key and loaded handle. Depends on lrucm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lrucm_req_if;
  import lrucm_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [KeyW-1:0]    key;
  logic [HandleW-1:0] handle_in;
  modport source (output valid, command, key, handle_in, input ready);
  modport sink   (input valid, command, key, handle_in, output ready);
endinterface
`default_nettype wire

// ===== hdl/lrucm_rsp_if.sv =====
// Result channel of the cache. Depends on lrucm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lrucm_rsp_if;
  import lrucm_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [KeyW-1:0]    key_out;
  logic [HandleW-1:0] handle_out;
  logic [WaitW-1:0]   waiter_count;
  logic               evicted;
  logic [KeyW-1:0]    evicted_key;
  modport source (output valid, status, key_out, handle_out, waiter_count, evicted,
                  evicted_key, input ready);
  modport sink   (input valid, status, key_out, handle_out, waiter_count, evicted,
                  evicted_key, output ready);
endinterface
`default_nettype wire

// ===== hdl/lrucm_cfg_if.sv =====
// Configuration write channel carrying max_entries. Depends on lrucm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lrucm_cfg_if;
  import lrucm_pkg::*;
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] max_entries;
  modport source (output valid, max_entries, input ready);
  modport sink   (input valid, max_entries, output ready);
endinterface
`default_nettype wire

// ===== hdl/lrucm_ctrl.sv =====
// Sequencing state machine of the cache: accept, lookup, execute.
// Depends on lrucm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lrucm_ctrl
  import lrucm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire lrucm_stat_t stat_i,
  output lrucm_cmd_t       cmd_o
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SLook = 2'd1;
  localparam logic [1:0] SExec = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == SIdle);
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SLook;
        end
      end
      SLook: begin
        cmd_o.lookup = !stat_i.key_null;
        state_d      = SExec;
      end
      SExec: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  // Every accepted word moves the controller into the lookup state.
  a_load_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == SLook) else $error("load not followed by lookup");
  // Execution always follows a lookup step.
  a_exec_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == SExec) |-> $past(state_q) == SLook) else $error("bad sequence");
endmodule
`default_nettype wire

// ===== hdl/lrucm_dp.sv =====
// Datapath of the cache: entry and pending tables, tag compares, recency
// ranks, eviction and the result register. Depends on lrucm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lrucm_dp
  import lrucm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lrucm_cmd_t         cmd_i,
  output lrucm_stat_t             stat_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               command_i,
  input  wire logic [KeyW-1:0]    key_i,
  input  wire logic [HandleW-1:0] handle_in_i,
  output logic [StatusW-1:0]      status_o,
  output logic [KeyW-1:0]         key_out_o,
  output logic [HandleW-1:0]      handle_out_o,
  output logic [WaitW-1:0]        waiter_count_o,
  output logic                    evicted_o,
  output logic [KeyW-1:0]         evicted_key_o
);
  // Stores.
  logic [KeyW-1:0]    ekey_q  [CacheDepth], ekey_d  [CacheDepth];
  logic [HandleW-1:0] ehdl_q  [CacheDepth], ehdl_d  [CacheDepth];
  logic [RankW-1:0]   erank_q [CacheDepth], erank_d [CacheDepth];
  logic [CacheDepth-1:0] evalid_q, evalid_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [KeyW-1:0]    pkey_q  [PendDepth], pkey_d  [PendDepth];
  logic [WaitW-1:0]   pwait_q [PendDepth], pwait_d [PendDepth];
  logic [PendDepth-1:0] pvalid_q, pvalid_d;
  logic [CfgW-1:0]    max_q;

  // Captured word and lookup results.
  logic               cmd_q;
  logic [KeyW-1:0]    key_q;
  logic [HandleW-1:0] hin_q;
  logic [CacheDepth-1:0] ehit_q, lru_q;
  logic [PendDepth-1:0]  phit_q, pfree_q;
  logic               full_q;

  // Result register.
  logic [StatusW-1:0] st_q, st_d;
  logic [KeyW-1:0]    kout_q;
  logic [HandleW-1:0] hout_q, hout_d;
  logic [WaitW-1:0]   wc_q, wc_d;
  logic               ev_q, ev_d;
  logic [KeyW-1:0]    evk_q, evk_d;

  // Lookup combinational values.
  logic [CacheDepth-1:0] ehit_c, lru_c;
  logic [PendDepth-1:0]  phit_c, pfree_c;
  logic [CfgW-1:0]       limit_c;
  logic                  pfound;

  // Execute combinational values.
  logic [HandleW-1:0]    hit_hdl;
  logic [RankW-1:0]      hit_rank;
  logic [WaitW-1:0]      pw_sel;
  logic [KeyW-1:0]       lru_key;
  logic [CacheDepth-1:0] keep, ins;
  logic                  efound;

  assign stat_o.key_null = (key_q == '0);

  // Effective capacity: zero acts as one, large values clamp to the depth.
  always_comb begin
    limit_c = max_q;
    if (max_q == '0) begin
      limit_c = CfgW'(1);
    end else if (max_q > CfgW'(CacheDepth)) begin
      limit_c = CfgW'(CacheDepth);
    end
  end

  // Parallel tag compares, least-recent pick and first free pending slot.
  always_comb begin
    pfound = 1'b0;
    for (int i = 0; i < CacheDepth; i++) begin
      ehit_c[i] = evalid_q[i] && (ekey_q[i] == key_q);
      lru_c[i]  = evalid_q[i] && (erank_q[i] == RankW'(count_q - CntW'(1)));
    end
    for (int j = 0; j < PendDepth; j++) begin
      phit_c[j]  = pvalid_q[j] && (pkey_q[j] == key_q);
      pfree_c[j] = !pvalid_q[j] && !pfound;
      if (!pvalid_q[j]) begin
        pfound = 1'b1;
      end
    end
  end

  // Selected values from the registered one-hot vectors.
  always_comb begin
    hit_hdl  = '0;
    hit_rank = '0;
    lru_key  = '0;
    pw_sel   = '0;
    for (int i = 0; i < CacheDepth; i++) begin
      if (ehit_q[i]) begin
        hit_hdl  = hit_hdl | ehdl_q[i];
        hit_rank = hit_rank | erank_q[i];
      end
      if (lru_q[i]) begin
        lru_key = lru_key | ekey_q[i];
      end
    end
    for (int j = 0; j < PendDepth; j++) begin
      if (phit_q[j]) begin
        pw_sel = pw_sel | pwait_q[j];
      end
    end
  end

  // Insertion slot: first entry free once the least recent one has gone.
  always_comb begin
    keep   = evalid_q & ~(full_q ? lru_q : '0);
    efound = 1'b0;
    for (int i = 0; i < CacheDepth; i++) begin
      ins[i] = !keep[i] && !efound;
      if (!keep[i]) begin
        efound = 1'b1;
      end
    end
  end

  // Execute step: result and next store contents.
  always_comb begin
    ekey_d   = ekey_q;
    ehdl_d   = ehdl_q;
    erank_d  = erank_q;
    evalid_d = evalid_q;
    count_d  = count_q;
    pkey_d   = pkey_q;
    pwait_d  = pwait_q;
    pvalid_d = pvalid_q;
    st_d     = StNull;
    hout_d   = '0;
    wc_d     = '0;
    ev_d     = 1'b0;
    evk_d    = '0;
    if (key_q == '0) begin
      st_d = StNull;
    end else if (cmd_q == CmdRequest) begin
      if (|ehit_q) begin
        // Hit: younger entries age by one, the hit one becomes newest.
        st_d   = StHit;
        hout_d = hit_hdl;
        for (int i = 0; i < CacheDepth; i++) begin
          if (ehit_q[i]) begin
            erank_d[i] = '0;
          end else if (evalid_q[i] && erank_q[i] < hit_rank) begin
            erank_d[i] = erank_q[i] + RankW'(1);
          end
        end
      end else if (|phit_q) begin
        // Merge into the outstanding load, saturating the waiter count.
        st_d = StMerged;
        wc_d = (pw_sel == '1) ? pw_sel : pw_sel + WaitW'(1);
        for (int j = 0; j < PendDepth; j++) begin
          if (phit_q[j]) begin
            pwait_d[j] = wc_d;
          end
        end
      end else if (|pfree_q) begin
        st_d = StIssue;
        wc_d = WaitW'(1);
        for (int j = 0; j < PendDepth; j++) begin
          if (pfree_q[j]) begin
            pvalid_d[j] = 1'b1;
            pkey_d[j]   = key_q;
            pwait_d[j]  = WaitW'(1);
          end
        end
      end else begin
        st_d = StPendFull;
      end
    end else begin
      if (!(|phit_q)) begin
        st_d = StNotPend;
      end else begin
        wc_d = pw_sel;
        for (int j = 0; j < PendDepth; j++) begin
          if (phit_q[j]) begin
            pvalid_d[j] = 1'b0;
            pkey_d[j]   = '0;
            pwait_d[j]  = '0;
          end
        end
        if (hin_q == '0) begin
          st_d = StFailed;
        end else begin
          st_d   = StInserted;
          hout_d = hin_q;
          if (|ehit_q) begin
            // Key already cached: overwrite the handle and make it newest.
            for (int i = 0; i < CacheDepth; i++) begin
              if (ehit_q[i]) begin
                ehdl_d[i]  = hin_q;
                erank_d[i] = '0;
              end else if (evalid_q[i] && erank_q[i] < hit_rank) begin
                erank_d[i] = erank_q[i] + RankW'(1);
              end
            end
          end else begin
            // Evict the least recent entry at capacity, then insert as newest.
            ev_d  = full_q;
            evk_d = full_q ? lru_key : '0;
            for (int i = 0; i < CacheDepth; i++) begin
              if (ins[i]) begin
                evalid_d[i] = 1'b1;
                ekey_d[i]   = key_q;
                ehdl_d[i]   = hin_q;
                erank_d[i]  = '0;
              end else if (keep[i]) begin
                erank_d[i] = erank_q[i] + RankW'(1);
              end else begin
                evalid_d[i] = 1'b0;
                ekey_d[i]   = '0;
                ehdl_d[i]   = '0;
                erank_d[i]  = '0;
              end
            end
            count_d = full_q ? count_q : count_q + CntW'(1);
          end
        end
      end
    end
  end

  // Control state and stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= CfgReset;
      evalid_q <= '0;
      count_q  <= '0;
      pvalid_q <= '0;
      for (int i = 0; i < CacheDepth; i++) begin
        ekey_q[i]  <= '0;
        ehdl_q[i]  <= '0;
        erank_q[i] <= '0;
      end
      for (int j = 0; j < PendDepth; j++) begin
        pkey_q[j]  <= '0;
        pwait_q[j] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        evalid_q <= evalid_d;
        count_q  <= count_d;
        pvalid_q <= pvalid_d;
        ekey_q   <= ekey_d;
        ehdl_q   <= ehdl_d;
        erank_q  <= erank_d;
        pkey_q   <= pkey_d;
        pwait_q  <= pwait_d;
      end
    end
  end

  // Captured word, lookup results and result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      key_q <= key_i;
      hin_q <= handle_in_i;
    end
    if (cmd_i.lookup) begin
      ehit_q  <= ehit_c;
      lru_q   <= lru_c;
      phit_q  <= phit_c;
      pfree_q <= pfree_c;
      full_q  <= ({{(CntW-CfgW+1){1'b0}}, limit_c} <= {1'b0, count_q});
    end
    if (cmd_i.exec) begin
      st_q   <= st_d;
      kout_q <= key_q;
      hout_q <= hout_d;
      wc_q   <= wc_d;
      ev_q   <= ev_d;
      evk_q  <= evk_d;
    end
  end

  assign status_o       = st_q;
  assign key_out_o      = kout_q;
  assign handle_out_o   = hout_q;
  assign waiter_count_o = wc_q;
  assign evicted_o      = ev_q;
  assign evicted_key_o  = evk_q;

  // Fill count tracks the valid entries.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) == $countones(evalid_q)) else $error("fill count mismatch");
  // Keys are unique in both tables.
  a_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |=> $onehot0(ehit_q) && $onehot0(phit_q)) else $error("duplicate key");
  // An insertion never finds the cache without a free slot.
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && st_d == StInserted && !(|ehit_q) |-> efound)
    else $error("no slot for insert");
endmodule
`default_nettype wire

// ===== hdl/lru_cache_with_miss_merge.sv =====
// Top level of the LRU cache with miss merging: controller and datapath.
// Depends on lrucm_pkg, the channel interfaces, lrucm_ctrl and lrucm_dp.
//
// Use: a request word (command 0) looks a key up and answers hit, merged,
// issue load or pending full; a completion word (command 1) carries the
// loaded handle and answers inserted (with any eviction), load failed or
// not pending. A null key answers null. Every accepted word gives exactly
// one result word.
// Channels: req (sink), rsp (source), cfg (sink, always ready) carrying
// max_entries. Words move at clock edges where valid and ready are high.
// Timing: one word at a time; a word is accepted, its tags are compared
// against all 16 entries and 8 pending slots in the next cycle, and the
// tables update and the result register loads in the execute state once
// the result register is free; a new word is accepted only after that.
// The sequence of accept, compare and update sets this.
// A waiting result does not block the next accept; the update step waits
// only if the previous result has not been taken.
// Reset clears all tables at once and sets max_entries to 16.
`timescale 1ns / 1ps
`default_nettype none
module lru_cache_with_miss_merge
  import lrucm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lrucm_req_if.sink   req,
  lrucm_rsp_if.source rsp,
  lrucm_cfg_if.sink   cfg
);
  lrucm_cmd_t  cmd;
  lrucm_stat_t stat;

  assign cfg.ready = 1'b1;

  lrucm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lrucm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg.valid),
    .cfg_data_i     (cfg.max_entries),
    .command_i      (req.command),
    .key_i          (req.key),
    .handle_in_i    (req.handle_in),
    .status_o       (rsp.status),
    .key_out_o      (rsp.key_out),
    .handle_out_o   (rsp.handle_out),
    .waiter_count_o (rsp.waiter_count),
    .evicted_o      (rsp.evicted),
    .evicted_key_o  (rsp.evicted_key)
  );
endmodule
`default_nettype wire

// ===== sim/lrucm_checker.sv =====
// Checker for the LRU cache with miss merging: predicts each result word
// from the accepted request and configuration words and compares them.
// Depends on lrucm_pkg and the three channel interfaces.
`timescale 1ns / 1ps
module lrucm_checker
  import lrucm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lrucm_req_if req,
  lrucm_rsp_if rsp,
  lrucm_cfg_if cfg,
  output int   fail_count,
  output int   pending_results
);
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [KeyW-1:0]    key_out;
    logic [HandleW-1:0] handle_out;
    logic [WaitW-1:0]   waiter_count;
    logic               evicted;
    logic [KeyW-1:0]    evicted_key;
  } result_t;

  // Mirror of the cache state.
  logic [KeyW-1:0]    ent_key  [CacheDepth];
  logic [HandleW-1:0] ent_hdl  [CacheDepth];
  logic               ent_vld  [CacheDepth];
  int                 ent_age  [CacheDepth];
  int                 fill;
  logic [KeyW-1:0]    pnd_key  [PendDepth];
  int                 pnd_wait [PendDepth];
  logic               pnd_vld  [PendDepth];
  logic [CfgW-1:0]    max_cfg;
  result_t            expected_q[$];

  assign pending_results = expected_q.size();

  // Move entry e to the front of the recency order.
  function automatic void make_recent(int e);
    int r;
    r = ent_age[e];
    for (int i = 0; i < CacheDepth; i++)
      if (ent_vld[i] && i != e && ent_age[i] < r) ent_age[i]++;
    ent_age[e] = 0;
  endfunction

  function automatic result_t predict_result(logic cmd, logic [KeyW-1:0] key,
                                             logic [HandleW-1:0] hin);
    result_t r;
    int e, p, lru, lim;
    r = '0;
    r.key_out = key;
    e = -1;
    p = -1;
    for (int i = CacheDepth - 1; i >= 0; i--) if (ent_vld[i] && ent_key[i] == key) e = i;
    for (int i = PendDepth - 1; i >= 0; i--) if (pnd_vld[i] && pnd_key[i] == key) p = i;
    if (key == '0) begin
      r.status = StNull;
    end else if (cmd == CmdRequest) begin
      if (e >= 0) begin
        make_recent(e);
        r.status = StHit;
        r.handle_out = ent_hdl[e];
      end else if (p >= 0) begin
        if (pnd_wait[p] < 255) pnd_wait[p]++;
        r.status = StMerged;
        r.waiter_count = pnd_wait[p];
      end else begin
        for (int i = PendDepth - 1; i >= 0; i--) if (!pnd_vld[i]) p = i;
        if (p < 0) begin
          r.status = StPendFull;
        end else begin
          pnd_vld[p] = 1'b1;
          pnd_key[p] = key;
          pnd_wait[p] = 1;
          r.status = StIssue;
          r.waiter_count = 1;
        end
      end
    end else if (p < 0) begin
      r.status = StNotPend;
    end else begin
      r.waiter_count = pnd_wait[p];
      pnd_vld[p] = 1'b0;
      pnd_key[p] = '0;
      pnd_wait[p] = 0;
      if (hin == '0) begin
        r.status = StFailed;
      end else begin
        if (e >= 0) begin
          ent_hdl[e] = hin;
          make_recent(e);
        end else begin
          lim = (max_cfg < 1) ? 1 : (max_cfg > CacheDepth) ? CacheDepth : int'(max_cfg);
          if (fill >= lim) begin
            lru = -1;
            for (int i = 0; i < CacheDepth; i++)
              if (ent_vld[i] && (lru < 0 || ent_age[i] > ent_age[lru])) lru = i;
            if (lru >= 0) begin
              r.evicted = 1'b1;
              r.evicted_key = ent_key[lru];
              ent_vld[lru] = 1'b0;
              ent_key[lru] = '0;
              ent_hdl[lru] = '0;
              ent_age[lru] = 0;
              fill--;
            end
          end
          for (int i = CacheDepth - 1; i >= 0; i--) if (!ent_vld[i]) e = i;
          if (e >= 0) begin
            for (int i = 0; i < CacheDepth; i++) if (ent_vld[i]) ent_age[i]++;
            ent_vld[e] = 1'b1;
            ent_key[e] = key;
            ent_hdl[e] = hin;
            ent_age[e] = 0;
            fill++;
          end
        end
        r.status = StInserted;
        r.handle_out = hin;
      end
    end
    return r;
  endfunction

  // Watch all channels at each edge; predict on accepted requests, compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < CacheDepth; i++) begin
        ent_key[i] = '0; ent_hdl[i] = '0; ent_vld[i] = 1'b0; ent_age[i] = 0;
      end
      for (int i = 0; i < PendDepth; i++) begin
        pnd_key[i] = '0; pnd_wait[i] = 0; pnd_vld[i] = 1'b0;
      end
      fill = 0;
      max_cfg = CfgReset;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) max_cfg = cfg.max_entries;
      if (req.valid && req.ready)
        expected_q.push_back(predict_result(req.command, req.key, req.handle_in));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.key_out, rsp.handle_out, rsp.waiter_count,
                rsp.evicted, rsp.evicted_key};
        if (expected_q.size() == 0) begin
          $error("result word with no expectation: key %h", got.key_out);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.status != exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, got.status);
            fail_count++;
          end
          if (got.key_out != exp_r.key_out) begin
            $error("key_out: expected %h, actual %h", exp_r.key_out, got.key_out);
            fail_count++;
          end
          if (got.handle_out != exp_r.handle_out) begin
            $error("handle_out: expected %h, actual %h", exp_r.handle_out, got.handle_out);
            fail_count++;
          end
          if (got.waiter_count != exp_r.waiter_count) begin
            $error("waiter_count: expected %0d, actual %0d", exp_r.waiter_count,
                   got.waiter_count);
            fail_count++;
          end
          if (got.evicted != exp_r.evicted) begin
            $error("evicted: expected %0d, actual %0d", exp_r.evicted, got.evicted);
            fail_count++;
          end
          if (got.evicted_key != exp_r.evicted_key) begin
            $error("evicted_key: expected %h, actual %h", exp_r.evicted_key,
                   got.evicted_key);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== sim/lru_cache_with_miss_merge_tb.sv =====
// Top of the testbench for the LRU cache with miss merging: clock, reset,
// stimulus, configuration phases and verdict. Depends on lrucm_pkg, the
// channel interfaces, lrucm_checker and the block itself.
`timescale 1ns / 1ps
module lru_cache_with_miss_merge_tb;
  import lrucm_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_results;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic [KeyW-1:0] key_pool[8];

  lrucm_req_if req ();
  lrucm_rsp_if rsp ();
  lrucm_cfg_if cfg ();

  lru_cache_with_miss_merge u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg)
  );

  lrucm_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req             (req),
    .rsp             (rsp),
    .cfg             (cfg),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver side: stall at random per the current phase.
  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one word and hold it until accepted; random idle before it.
  // Valid stays high after acceptance until the next idle cycle or drain.
  task automatic send_word(logic cmd, logic [KeyW-1:0] key, logic [HandleW-1:0] hdl);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.command   <= cmd;
    req.key       <= key;
    req.handle_in <= hdl;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CfgW-1:0] value);
    drain_results();
    cfg.valid       <= 1'b1;
    cfg.max_entries <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed miss, merge, completion and hit traffic on a small key set.
  task automatic random_words(int count);
    logic [KeyW-1:0] k;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      k = ($urandom_range(3) == 0) ? key_pool[$urandom_range(7)]
                                   : KeyW'($urandom_range(40) + 1);
      if (sel < 3) k = '0;
      else if (sel < 6) k = $urandom;
      if (sel < 55)
        send_word(CmdRequest, k, $urandom);
      else if (sel < 90)
        send_word(CmdComplete, k, ($urandom_range(9) == 0) ? '0 : HandleW'($urandom));
      else
        send_word(CmdComplete, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    req.valid = 1'b0;
    req.command = CmdRequest;
    req.key = '0;
    req.handle_in = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.max_entries = '0;
    key_pool = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: null key, miss, merge, insert, hit, failed load, not pending.
    send_word(CmdRequest, '0, '0);
    send_word(CmdComplete, '0, 32'hFFFF_FFFF);
    send_word(CmdRequest, 32'hFFFF_FFFF, '0);
    send_word(CmdRequest, 32'hFFFF_FFFF, '0);
    send_word(CmdComplete, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CmdRequest, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CmdRequest, 32'h0000_0001, '0);
    send_word(CmdComplete, 32'h0000_0001, '0);
    send_word(CmdComplete, 32'h0000_0001, 32'h1);
    send_word(CmdRequest, 32'hFFFF_FFFF, '0);
    send_word(CmdRequest, 32'hFFFF_FFFF, '0);
    send_word(CmdComplete, 32'hFFFF_FFFF, 32'h8000_0000);
    // Fill the pending table, then one more miss finds it full.
    for (int i = 0; i < PendDepth + 1; i++) send_word(CmdRequest, KeyW'(100 + i), '0);
    // Waiter saturation on one pending key.
    for (int i = 0; i < 260; i++) send_word(CmdRequest, 32'd100, '0);
    for (int i = 0; i < PendDepth; i++) send_word(CmdComplete, KeyW'(100 + i), KeyW'(i + 1));

    // Limits at the extremes; lowering below the fill keeps it.
    write_limit(5'd0);
    random_words(120);
    write_limit(5'd31);
    random_words(120);
    write_limit(5'd1);
    random_words(100);

    // Sender holds off until everything has come back.
    drain_results();
    write_limit(5'd4);
    send_idle_pct = 50;
    random_words(250);
    write_limit(5'd16);
    send_idle_pct = 0;
    recv_stall_pct = 50;
    random_words(250);
    write_limit(5'd2);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    random_words(250);
    write_limit(5'd8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_words(200);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
